### rtl/tksel_pkg.sv
// Shared types and constants for the top-k score selector.
// No dependencies; every other file in rtl/ imports this package.
package tksel_pkg;

    localparam int SCORE_W          = 32;
    localparam int INDEX_W          = 16;
    localparam int RANK_W           = 4;
    localparam int TOPC_W           = 5;
    localparam int OUT_LIMIT        = 16;
    localparam int DEF_MAX_TOP      = 16;
    localparam int DEF_GALLERY_SIZE = 65536;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    // one classified score on its way from the front to the back
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
        logic                      keep;   // inside the gallery, goes through the ranking
        logic                      last;   // closes the row
        logic                      ovf;    // row has seen an item past the gallery
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } q_stat_t;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } back_state_t;

endpackage

### rtl/tksel_front.sv
// Front end: takes start transactions, numbers scores, flags gallery overflow.
// Depends on tksel_pkg; feeds tksel_queue.
module tksel_front #(
    parameter int GALLERY_SIZE = tksel_pkg::DEF_GALLERY_SIZE
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [tksel_pkg::SCORE_W-1:0]  score,
    input  logic                                  row_end,
    input  tksel_pkg::q_stat_t                    q_stat,
    output logic                                  busy,
    output tksel_pkg::push_t                      push
);
    import tksel_pkg::*;

    localparam int IDX_W = $clog2(GALLERY_SIZE + 1);

    logic [IDX_W-1:0] next_index_reg, next_index_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             ignored;

    assign busy    = q_stat.full;
    assign accept  = start && !busy;
    assign ignored = (next_index_reg == IDX_W'(GALLERY_SIZE));

    always_comb
    begin
        push.valid      = accept && (!ignored || row_end);
        push.item.score = score;
        push.item.index = INDEX_W'(next_index_reg);
        push.item.keep  = !ignored;
        push.item.last  = row_end;
        push.item.ovf   = ovf_reg || ignored;
    end

    always_comb
    begin
        next_index_next = next_index_reg;
        ovf_next        = ovf_reg;
        if (accept)
        begin
            if (row_end)
            begin
                next_index_next = '0;
                ovf_next        = 1'b0;
            end
            else if (ignored)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                next_index_next = next_index_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_index_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            next_index_reg <= next_index_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

### rtl/tksel_queue.sv
// Short FIFO of classified items between front and back.
// Depends on tksel_pkg.
module tksel_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  tksel_pkg::push_t   push,
    input  logic               pop,
    output tksel_pkg::item_t   head,
    output tksel_pkg::q_stat_t q_stat
);
    import tksel_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_pop;

    assign q_stat.nonempty = (fill_reg != '0);
    assign q_stat.full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head            = entry_reg[rd_ptr_reg];
    assign do_pop          = pop && q_stat.nonempty;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push.valid && !do_pop)
            fill_next = fill_reg + (QPTR_W+1)'(1);
        else if (!push.valid && do_pop)
            fill_next = fill_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### rtl/tksel_back.sv
// Back end: sorted chain of compare cells holding the best pairs, result emitter,
// and the top_count register. Depends on tksel_pkg; fed by tksel_queue.
module tksel_back #(
    parameter int MAX_TOP = tksel_pkg::DEF_MAX_TOP
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  top_count_we,
    input  logic [tksel_pkg::TOPC_W-1:0]          top_count_wdata,
    input  tksel_pkg::item_t                      head,
    input  tksel_pkg::q_stat_t                    q_stat,
    output logic                                  pop,
    output logic                                  result_valid,
    output logic [tksel_pkg::INDEX_W-1:0]         best_index,
    output logic signed [tksel_pkg::SCORE_W-1:0]  best_score,
    output logic [tksel_pkg::RANK_W-1:0]          rank,
    output logic                                  overflowed,
    output logic                                  final_res
);
    import tksel_pkg::*;

    localparam int DEPTH = (MAX_TOP < OUT_LIMIT) ? MAX_TOP : OUT_LIMIT;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // cells kept in descending order; for equal scores the newer pair sits first
    logic signed [SCORE_W-1:0] cell_score_reg  [DEPTH];
    logic signed [SCORE_W-1:0] cell_score_next [DEPTH];
    logic [INDEX_W-1:0]        cell_index_reg  [DEPTH];
    logic [INDEX_W-1:0]        cell_index_next [DEPTH];
    logic signed [SCORE_W-1:0] prev_score [DEPTH];
    logic signed [SCORE_W-1:0] up_score   [DEPTH];
    logic [INDEX_W-1:0]        prev_index [DEPTH];
    logic [INDEX_W-1:0]        up_index   [DEPTH];
    logic [DEPTH-1:0]          ge;
    logic [DEPTH-1:0]          ge_prev;
    logic [DEPTH-1:0]          gt_last;

    back_state_t       state_reg, state_next;
    logic [TOPC_W-1:0] top_count_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              ovf_reg, ovf_next;

    logic [TOPC_W-1:0] t_raw;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  count_upd;
    logic              grow;
    logic              beats_last;
    logic              do_ins;
    logic              row_close;
    logic              shift_up;
    logic              last_out;

    // clamp top_count to one and to the cell count
    always_comb
    begin
        t_raw = (top_count_reg == '0) ? TOPC_W'(1) : top_count_reg;
        if (int'(t_raw) > DEPTH)
            eff_count = CNT_W'(DEPTH);
        else
            eff_count = CNT_W'(t_raw);
    end

    // neighbor taps for the insertion and emission shifts
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_tap
        if (g == 0)
        begin : g_head
            assign prev_score[g] = cell_score_reg[g];
            assign prev_index[g] = cell_index_reg[g];
            assign ge_prev[g]    = 1'b0;
        end
        else
        begin : g_body
            assign prev_score[g] = cell_score_reg[g-1];
            assign prev_index[g] = cell_index_reg[g-1];
            assign ge_prev[g]    = ge[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_tail
            assign up_score[g] = cell_score_reg[g];
            assign up_index[g] = cell_index_reg[g];
        end
        else
        begin : g_mid
            assign up_score[g] = cell_score_reg[g+1];
            assign up_index[g] = cell_index_reg[g+1];
        end
    end

    // per-cell compares; empty cells always compare as beaten by the new pair
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i]      = (i >= int'(count_reg)) || (head.score >= cell_score_reg[i]);
            gt_last[i] = (i + 1 == int'(count_reg)) && (head.score > cell_score_reg[i]);
        end
    end

    assign pop        = (state_reg == ST_RUN);
    assign row_close  = pop && q_stat.nonempty && head.last;
    assign grow       = (count_reg < eff_count);
    assign beats_last = |gt_last;
    assign do_ins     = pop && q_stat.nonempty && head.keep && (grow || beats_last);
    assign shift_up   = (state_reg == ST_EMIT);
    assign last_out   = ((pos_reg + CNT_W'(1)) == n_reg);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_score_next[i] = cell_score_reg[i];
            cell_index_next[i] = cell_index_reg[i];
            priority if (shift_up)
            begin
                cell_score_next[i] = up_score[i];
                cell_index_next[i] = up_index[i];
            end
            else if (do_ins && ge_prev[i])
            begin
                cell_score_next[i] = prev_score[i];
                cell_index_next[i] = prev_index[i];
            end
            else if (do_ins && ge[i])
            begin
                cell_score_next[i] = head.score;
                cell_index_next[i] = head.index;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (row_close && (count_upd != '0))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (last_out)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // counters and row bookkeeping
    always_comb
    begin
        count_upd  = (do_ins && grow) ? count_reg + CNT_W'(1) : count_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                count_next = count_upd;
                if (row_close)
                begin
                    pos_next = '0;
                    n_next   = (count_upd < eff_count) ? count_upd : eff_count;
                    ovf_next = head.ovf;
                end
            end
            ST_EMIT:
            begin
                pos_next = pos_reg + CNT_W'(1);
                if (last_out)
                    count_next = '0;
            end
            default: count_next = '0;
        endcase
    end

    // result ports
    always_comb
    begin
        result_valid = (state_reg == ST_EMIT);
        best_score   = cell_score_reg[0];
        best_index   = cell_index_reg[0];
        rank         = RANK_W'(pos_reg);
        overflowed   = ovf_reg;
        final_res    = result_valid && last_out;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_score_reg[i] <= cell_score_next[i];
            cell_index_reg[i] <= cell_index_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            top_count_reg <= TOPC_W'(1);
            count_reg     <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (top_count_we)
                top_count_reg <= top_count_wdata;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### rtl/top_k_score_selector_core.sv
// Top level of the streaming top-k score selector: front, queue, back.
// Depends on tksel_pkg, tksel_front, tksel_queue and tksel_back.
//
//  port group     direction  handshake         payload
//  score input    in         start / busy      score, row_end
//  top_count      in         top_count_we      top_count_wdata
//  result         out        result_valid      best_index, best_score, rank,
//                                              overflowed, final_res
//
// A score is taken whenever start is high and busy is low; the compare cells insert
// one queued score per cycle while not emitting. On a row end the back shifts n results
// (n = kept pairs, capped by top_count) out of the head cell, one per cycle, and inserts
// nothing meanwhile; the four-entry queue keeps start open during emission until it fills.
// Reset (rst_n low, asynchronous) clears the row state and sets top_count to 1.
// The receiver cannot stall: each result is valid for exactly one cycle.
module top_k_score_selector_core #(
    parameter int MAX_TOP      = tksel_pkg::DEF_MAX_TOP,
    parameter int GALLERY_SIZE = tksel_pkg::DEF_GALLERY_SIZE
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tksel_pkg::SCORE_W-1:0]  score,
    input  logic                                  row_end,
    input  logic                                  top_count_we,
    input  logic [tksel_pkg::TOPC_W-1:0]          top_count_wdata,
    output logic                                  result_valid,
    output logic [tksel_pkg::INDEX_W-1:0]         best_index,
    output logic signed [tksel_pkg::SCORE_W-1:0]  best_score,
    output logic [tksel_pkg::RANK_W-1:0]          rank,
    output logic                                  overflowed,
    output logic                                  final_res
);
    import tksel_pkg::*;

    push_t   push;
    q_stat_t q_stat;
    item_t   head;
    logic    pop;

    tksel_front #(
        .GALLERY_SIZE (GALLERY_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .score   (score),
        .row_end (row_end),
        .q_stat  (q_stat),
        .busy    (busy),
        .push    (push)
    );

    tksel_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    tksel_back #(
        .MAX_TOP (MAX_TOP)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .top_count_we    (top_count_we),
        .top_count_wdata (top_count_wdata),
        .head            (head),
        .q_stat          (q_stat),
        .pop             (pop),
        .result_valid    (result_valid),
        .best_index      (best_index),
        .best_score      (best_score),
        .rank            (rank),
        .overflowed      (overflowed),
        .final_res       (final_res)
    );

endmodule
